FILE: rtl/core/tssm_pkg.sv
`timescale 1ns / 1ps

package tssm_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned FuncW        = 3;
  localparam int unsigned StatusW      = 2;

  // Operation codes; the unused codes behave as a query.
  typedef enum logic [FuncW-1:0] {
    OpPushOne = 3'd0,
    OpPushTwo = 3'd1,
    OpPopOne  = 3'd2,
    OpPopTwo  = 3'd3,
    OpQuery   = 3'd4
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StUnder = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle = 2'b01,
    FsmResp = 2'b10
  } fsm_e;

endpackage

FILE: rtl/core/two_stacks_shared_memory.sv
`timescale 1ns / 1ps
// The transfer cycle updates the counts and drives the memory port; the response state then
// takes the registered read data into the output register, waiting while the output still
// holds an earlier result. A new item is taken only after the result of the last one has
// been loaded into the output register.
// Reset (rst_ni, asynchronous, active low) empties both stacks and clears all handshake state;
// the memory itself is not cleared and needs no clearing pass.
module two_stacks_shared_memory
  import tssm_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [FuncW-1:0]          func_i,
  input  logic signed [DataW-1:0]   data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [StatusW-1:0]        status_o,
  output logic signed [DataW-1:0]   top_one_o,
  output logic signed [DataW-1:0]   top_two_o,
  output logic                      empty_one_o,
  output logic                      empty_two_o
);

  // Counts must hold DEPTH itself; the address only needs to index DEPTH words.
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [CW:0] DepthW = (CW + 1)'(DEPTH);

  // The shared storage. Stack one occupies the low words, stack two the high words.
  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rdata_q;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  fsm_e            state_q, state_d;
  logic [CW-1:0]   count_one_q, count_one_d;
  logic [CW-1:0]   count_two_q, count_two_d;

  // The top of each stack is cached in a register so that a push needs no read; only a
  // pop has to fetch the word that becomes the new top.
  logic [DataW-1:0] top_one_q, top_two_q;
  logic             pend_one_q, pend_two_q;
  logic             pend_one_d, pend_two_d;
  status_e          status_q, status_d;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [DataW-1:0] out_top_one_q, out_top_two_q;
  logic             out_empty_one_q, out_empty_two_q;

  logic             accept, load_out;
  logic [CW:0]      count_sum;
  logic             has_room;

  assign in_ready_o = (state_q == FsmIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == FsmResp) && (!out_valid_q || out_ready_i);

  assign count_sum = {1'b0, count_one_q} + {1'b0, count_two_q};
  assign has_room  = count_sum < DepthW;

  // Decode of the operation in the transfer cycle: new counts, the memory access and status.
  always_comb begin
    logic [CW:0] tmp;
    count_one_d = count_one_q;
    count_two_d = count_two_q;
    pend_one_d  = 1'b0;
    pend_two_d  = 1'b0;
    status_d    = StOk;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    tmp         = '0;
    case (func_e'(func_i))
      OpPushOne: begin
        if (has_room) begin
          mem_we      = accept;
          mem_waddr   = count_one_q[AW-1:0];
          count_one_d = count_one_q + CW'(1);
        end else begin
          status_d = StFull;
        end
      end
      OpPushTwo: begin
        if (has_room) begin
          mem_we      = accept;
          tmp         = DepthW - {1'b0, count_two_q} - (CW + 1)'(1);
          mem_waddr   = tmp[AW-1:0];
          count_two_d = count_two_q + CW'(1);
        end else begin
          status_d = StFull;
        end
      end
      OpPopOne: begin
        if (count_one_q == '0) begin
          status_d = StUnder;
        end else begin
          count_one_d = count_one_q - CW'(1);
          // The word below the old top becomes the new top, unless the stack empties.
          if (count_one_q > CW'(1)) begin
            mem_re     = accept;
            pend_one_d = 1'b1;
            tmp        = {1'b0, count_one_q} - (CW + 1)'(2);
            mem_raddr  = tmp[AW-1:0];
          end
        end
      end
      OpPopTwo: begin
        if (count_two_q == '0) begin
          status_d = StUnder;
        end else begin
          count_two_d = count_two_q - CW'(1);
          if (count_two_q > CW'(1)) begin
            mem_re     = accept;
            pend_two_d = 1'b1;
            tmp        = DepthW - {1'b0, count_two_q} + (CW + 1)'(1);
            mem_raddr  = tmp[AW-1:0];
          end
        end
      end
      default: begin
        status_d = StOk;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FsmIdle: if (accept) state_d = FsmResp;
      FsmResp: if (load_out) state_d = FsmIdle;
      default: state_d = FsmIdle;
    endcase
  end

  // Synchronous memory: one write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= data_i;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      count_one_q <= '0;
      count_two_q <= '0;
      pend_one_q  <= 1'b0;
      pend_two_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_one_q <= count_one_d;
        count_two_q <= count_two_d;
        pend_one_q  <= pend_one_d;
        pend_two_q  <= pend_two_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: cached tops, pending status and the output register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      if (mem_we && (func_e'(func_i) == OpPushOne)) begin
        top_one_q <= data_i;
      end
      if (mem_we && (func_e'(func_i) == OpPushTwo)) begin
        top_two_q <= data_i;
      end
    end
    if (load_out) begin
      if (pend_one_q) begin
        top_one_q <= rdata_q;
      end
      if (pend_two_q) begin
        top_two_q <= rdata_q;
      end
      out_status_q    <= status_q;
      out_top_one_q   <= (count_one_q == '0) ? '0 : (pend_one_q ? rdata_q : top_one_q);
      out_top_two_q   <= (count_two_q == '0) ? '0 : (pend_two_q ? rdata_q : top_two_q);
      out_empty_one_q <= (count_one_q == '0);
      out_empty_two_q <= (count_two_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign top_one_o   = out_top_one_q;
  assign top_two_o   = out_top_two_q;
  assign empty_one_o = out_empty_one_q;
  assign empty_two_o = out_empty_two_q;

  // The two stacks never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_one_q} + {1'b0, count_two_q}) <= DepthW)
    else $error("stacks overlap");

  // An accepted item holds off the next one in the cycle after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item taken during a response cycle");

  // A memory access only ever happens in the transfer cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we || mem_re) |-> accept)
    else $error("memory accessed outside a transfer");

  // An empty stack one reports a zero top.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_one_o) |-> (top_one_o == '0))
    else $error("empty stack one reports a non-zero top");

endmodule
